[sv/cau_pkg.sv]
// Shared command and status codes for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    // Operation selected by the command field of an input transaction.
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Status codes returned with every result.
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_SAT = 2'd1;
    localparam logic [1:0] STAT_DZ  = 2'd2;

endpackage

`default_nettype wire

[sv/complex_arithmetic_unit.sv]
// Pipelined complex add, subtract, multiply and divide unit in signed fixed point.
`default_nettype none

// The unit takes two complex operands (a + jb) and (c + jd) in signed fixed point
// with FRAC_BITS fraction bits and returns their sum, difference, product or quotient.
// It is one pipeline that takes a new transaction in every cycle unless the output
// stalls, and holds no state between transactions. The divider has one register
// stage for an overflow check and one for each of its DATA_WIDTH + 1 quotient bits.
// Add, subtract and multiply results go through the same stages, so results leave
// in input order. The stages ahead of the divider hold the six multipliers, the sums
// and the magnitude conversion. Products and quotients are truncated toward zero. A
// part that leaves the signed range saturates, and the status then reads saturated.
// Dividing by 0 + 0j returns zeros with a divide-by-zero status. While the output
// transaction waits, the whole pipeline holds and s_axis_tready is low.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // Fields from bit 0: first_real, first_imag, second_real, second_imag.
    input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // Fields from bit 0: command.
    input  wire logic [1:0]                              s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // Fields from bit 0: result_real, result_imag.
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
    // Fields from bit 0: status.
    output logic [1:0]                                   m_axis_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;
    localparam int PW    = 2*DW + 2;                 // signed sums of two products
    localparam int DNW   = 2*DW;                     // divisor c*c + d*d
    localparam int QW    = DW + 1;                   // quotient bits kept
    localparam int WW    = 3*DW + FRAC_BITS + 2;     // divider remainder width
    localparam int NST   = DW + 3;                   // load, overflow check, quotient bits
    localparam logic [WW-1:0] HALF = WW'(1) << (DW - 1);

    typedef struct packed {
        cau_pkg::cmd_t   cmd;
        logic            dz;
        logic [DNW-1:0]  den;
        logic            re_neg;
        logic            im_neg;
        logic [WW-1:0]   re_rem;
        logic [WW-1:0]   im_rem;
        logic [QW-1:0]   re_q;
        logic [QW-1:0]   im_q;
        logic            re_ovf;
        logic            im_ovf;
    } div_stage_t;

    // The pipeline advances whenever the output register can take a new value.
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: operand sums and the six products.
    logic signed [DW-1:0]   op_a, op_b, op_c, op_d;
    cau_pkg::cmd_t          in_cmd;
    logic signed [DW:0]     sre_next, sim_next;
    logic signed [2*DW-1:0] ac_next, bd_next, ad_next, bc_next, cc_next, dd_next;

    assign op_a   = $signed(s_axis_tdata[DW-1:0]);
    assign op_b   = $signed(s_axis_tdata[2*DW-1:DW]);
    assign op_c   = $signed(s_axis_tdata[3*DW-1:2*DW]);
    assign op_d   = $signed(s_axis_tdata[4*DW-1:3*DW]);
    assign in_cmd = cau_pkg::cmd_t'(s_axis_tuser);

    always_comb
    begin
        if (in_cmd == cau_pkg::CMD_SUB)
        begin
            sre_next = (DW+1)'(op_a) - (DW+1)'(op_c);
            sim_next = (DW+1)'(op_b) - (DW+1)'(op_d);
        end
        else
        begin
            sre_next = (DW+1)'(op_a) + (DW+1)'(op_c);
            sim_next = (DW+1)'(op_b) + (DW+1)'(op_d);
        end
        ac_next = (2*DW)'(op_a) * (2*DW)'(op_c);
        bd_next = (2*DW)'(op_b) * (2*DW)'(op_d);
        ad_next = (2*DW)'(op_a) * (2*DW)'(op_d);
        bc_next = (2*DW)'(op_b) * (2*DW)'(op_c);
        cc_next = (2*DW)'(op_c) * (2*DW)'(op_c);
        dd_next = (2*DW)'(op_d) * (2*DW)'(op_d);
    end

    logic                   s1_valid_reg;
    cau_pkg::cmd_t          s1_cmd_reg;
    logic signed [DW:0]     s1_sre_reg, s1_sim_reg;
    logic signed [2*DW-1:0] s1_ac_reg, s1_bd_reg, s1_ad_reg, s1_bc_reg, s1_cc_reg, s1_dd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg <= in_cmd;
            s1_sre_reg <= sre_next;
            s1_sim_reg <= sim_next;
            s1_ac_reg  <= ac_next;
            s1_bd_reg  <= bd_next;
            s1_ad_reg  <= ad_next;
            s1_bc_reg  <= bc_next;
            s1_cc_reg  <= cc_next;
            s1_dd_reg  <= dd_next;
        end
    end

    // Stage 2: the real and imaginary numerators and the divisor.
    logic signed [PW-1:0] re_next, im_next;
    logic [DNW-1:0]       den_next;

    always_comb
    begin
        case (s1_cmd_reg)
            cau_pkg::CMD_MUL:
            begin
                re_next = PW'(s1_ac_reg) - PW'(s1_bd_reg);
                im_next = PW'(s1_ad_reg) + PW'(s1_bc_reg);
            end
            cau_pkg::CMD_DIV:
            begin
                re_next = PW'(s1_ac_reg) + PW'(s1_bd_reg);
                im_next = PW'(s1_bc_reg) - PW'(s1_ad_reg);
            end
            default:
            begin
                re_next = PW'(s1_sre_reg);
                im_next = PW'(s1_sim_reg);
            end
        endcase
        den_next = DNW'(unsigned'(s1_cc_reg)) + DNW'(unsigned'(s1_dd_reg));
    end

    logic                 s2_valid_reg;
    cau_pkg::cmd_t        s2_cmd_reg;
    logic signed [PW-1:0] s2_re_reg, s2_im_reg;
    logic [DNW-1:0]       s2_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_re_reg  <= re_next;
            s2_im_reg  <= im_next;
            s2_den_reg <= den_next;
        end
    end

    // Stage 3: sign and magnitude. Multiply drops its fraction bits here; divide
    // scales its numerator up so the quotient carries FRAC_BITS fraction bits.
    div_stage_t          load_next;
    logic [PW-1:0]       re_abs, im_abs;

    always_comb
    begin
        re_abs = s2_re_reg[PW-1] ? unsigned'(-s2_re_reg) : unsigned'(s2_re_reg);
        im_abs = s2_im_reg[PW-1] ? unsigned'(-s2_im_reg) : unsigned'(s2_im_reg);
        load_next.cmd    = s2_cmd_reg;
        load_next.dz     = (s2_den_reg == '0);
        load_next.den    = s2_den_reg;
        load_next.re_neg = s2_re_reg[PW-1];
        load_next.im_neg = s2_im_reg[PW-1];
        load_next.re_q   = '0;
        load_next.im_q   = '0;
        load_next.re_ovf = 1'b0;
        load_next.im_ovf = 1'b0;
        case (s2_cmd_reg)
            cau_pkg::CMD_MUL:
            begin
                load_next.re_rem = WW'(re_abs >> FRAC_BITS);
                load_next.im_rem = WW'(im_abs >> FRAC_BITS);
            end
            cau_pkg::CMD_DIV:
            begin
                load_next.re_rem = WW'(re_abs) << FRAC_BITS;
                load_next.im_rem = WW'(im_abs) << FRAC_BITS;
            end
            default:
            begin
                load_next.re_rem = WW'(re_abs);
                load_next.im_rem = WW'(im_abs);
            end
        endcase
    end

    div_stage_t       dv_reg [NST];
    logic [NST-1:0]   dv_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else if (en)
        begin
            dv_valid_reg <= {dv_valid_reg[NST-2:0], s2_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= load_next;
        end
    end

    // Divider stages: the first checks for a quotient too large to keep, each later
    // one settles one quotient bit from the top down. Other commands pass untouched.
    for (genvar j = 1; j < NST; j++)
    begin : g_div
        localparam int K  = (j == 1) ? DW + 1 : DW + 2 - j;
        // Quotient bit settled here; the overflow stage settles none.
        localparam int QB = (j == 1) ? 0 : K;

        div_stage_t     step_next;
        logic [WW-1:0]  dsh;
        logic           is_div, re_ge, im_ge;

        always_comb
        begin
            step_next = dv_reg[j-1];
            dsh       = WW'(dv_reg[j-1].den) << K;
            is_div    = (dv_reg[j-1].cmd == cau_pkg::CMD_DIV);
            re_ge     = is_div && (dv_reg[j-1].re_rem >= dsh);
            im_ge     = is_div && (dv_reg[j-1].im_rem >= dsh);
            if (j == 1)
            begin
                step_next.re_ovf = re_ge;
                step_next.im_ovf = im_ge;
            end
            else
            begin
                if (re_ge)
                begin
                    step_next.re_rem   = dv_reg[j-1].re_rem - dsh;
                    step_next.re_q[QB] = 1'b1;
                end
                if (im_ge)
                begin
                    step_next.im_rem   = dv_reg[j-1].im_rem - dsh;
                    step_next.im_q[QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j] <= step_next;
            end
        end
    end

    // Output stage: pick the magnitude, saturate and return to two's complement.
    div_stage_t     fin;
    logic           fin_div, re_sat, im_sat;
    logic [WW-1:0]  re_mag, im_mag;
    logic [DW-1:0]  re_out, im_out;
    logic [1:0]     status_next;

    always_comb
    begin
        fin     = dv_reg[NST-1];
        fin_div = (fin.cmd == cau_pkg::CMD_DIV);
        re_mag  = fin_div ? WW'(fin.re_q) : fin.re_rem;
        im_mag  = fin_div ? WW'(fin.im_q) : fin.im_rem;
        re_sat  = (fin_div && fin.re_ovf) ||
                  (fin.re_neg ? (re_mag > HALF) : (re_mag > HALF - WW'(1)));
        im_sat  = (fin_div && fin.im_ovf) ||
                  (fin.im_neg ? (im_mag > HALF) : (im_mag > HALF - WW'(1)));
        if (re_sat)
            re_out = fin.re_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            re_out = fin.re_neg ? DW'(-re_mag) : DW'(re_mag);
        if (im_sat)
            im_out = fin.im_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            im_out = fin.im_neg ? DW'(-im_mag) : DW'(im_mag);
        if (fin_div && fin.dz)
        begin
            re_out      = '0;
            im_out      = '0;
            status_next = cau_pkg::STAT_DZ;
        end
        else if (re_sat || im_sat)
        begin
            status_next = cau_pkg::STAT_SAT;
        end
        else
        begin
            status_next = cau_pkg::STAT_OK;
        end
    end

    logic           out_valid_reg;
    logic [DW-1:0]  out_re_reg, out_im_reg;
    logic [1:0]     out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg     <= re_out;
            out_im_reg     <= im_out;
            out_status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_im_reg, out_re_reg});
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

[sv/cau_checker.sv]
// Port-level checker for the complex arithmetic unit and its bind statement.
`default_nettype none

module cau_checker #(
    parameter int DATA_WIDTH = 16
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    input wire logic [1:0]                           s_axis_tuser,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input wire logic [1:0]                           m_axis_tuser
);

    // Input is refused only while a finished result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without an output stall");

    // The status is always one of the defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == cau_pkg::STAT_OK ||
                           m_axis_tuser == cau_pkg::STAT_SAT ||
                           m_axis_tuser == cau_pkg::STAT_DZ))
        else $error("undefined status code");

    // A divide by zero returns zeros in both parts.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == cau_pkg::STAT_DZ) |->
            (m_axis_tdata[2*DATA_WIDTH-1:0] == '0))
        else $error("divide by zero result not zero");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (.*);

`default_nettype wire
